FILE: rtl/lkf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkf_pkg
// Shared types and constants of the LED keyframe fade sequencer.
// ----------------------------------------------------------------------------
package lkf_pkg;

  localparam int LKF_RING_SLOTS = 10;

  localparam int LEVEL_W  = 8;
  localparam int FADE_W   = 16;
  localparam int TIME_W   = 32;
  localparam int QUEUED_W = 4;
  localparam int PROD_W   = LEVEL_W + FADE_W;

  // Serial blend: one multiplier bit per cycle, then one quotient bit per cycle.
  localparam int MUL_STEPS  = LEVEL_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int CALC_STEPS = MUL_STEPS + DIV_STEPS;
  localparam int STEP_W     = $clog2(CALC_STEPS);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] vibro;
    logic [FADE_W-1:0]  fade;
  } kf_t;

  typedef struct packed {
    logic start;
    logic mul_step;
    logic div_step;
  } lane_ctl_t;

endpackage

FILE: rtl/lkf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkf_store
// Keyframe ring memory: one write port, two registered read ports.
// An entry never written reads as zeros.
// ----------------------------------------------------------------------------
module lkf_store
  import lkf_pkg::*;
#(
  parameter int RING_SLOTS = LKF_RING_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(RING_SLOTS)-1:0] wr_addr,
  input  kf_t                           wr_data,
  input  logic [$clog2(RING_SLOTS)-1:0] rd_addr_a,
  input  logic [$clog2(RING_SLOTS)-1:0] rd_addr_b,
  output kf_t                           rd_data_a,
  output kf_t                           rd_data_b
);

  kf_t                  mem [RING_SLOTS];
  logic [RING_SLOTS-1:0] valid_r;
  kf_t                  rd_data_a_r;
  kf_t                  rd_data_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a_r <= valid_r[rd_addr_a] ? mem[rd_addr_a] : '0;
    rd_data_b_r <= valid_r[rd_addr_b] ? mem[rd_addr_b] : '0;
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

FILE: rtl/lkf_blend_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkf_blend_lane
// Bit-serial (level * coef) / divisor: shift-add multiply, MSB first, then
// restoring division that shifts quotient bits into the same register.
// ----------------------------------------------------------------------------
module lkf_blend_lane
  import lkf_pkg::*;
(
  input  logic               clk,
  input  lane_ctl_t          ctl,
  input  logic [LEVEL_W-1:0] level_in,
  input  logic [FADE_W-1:0]  coef,
  input  logic [FADE_W-1:0]  divisor,
  output logic [LEVEL_W-1:0] quot
);

  logic [LEVEL_W-1:0] level_r;
  logic [PROD_W-1:0]  work_r;
  logic [FADE_W-1:0]  rem_r;
  logic [FADE_W:0]    trial;
  logic [FADE_W:0]    diff;
  logic               q_bit;
  logic [PROD_W-1:0]  addend;

  assign addend = level_r[LEVEL_W-1] ? {{(PROD_W-FADE_W){1'b0}}, coef} : '0;
  assign trial  = {rem_r, work_r[PROD_W-1]};
  assign diff   = trial - {1'b0, divisor};
  assign q_bit  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      level_r <= level_in;
      work_r  <= '0;
      rem_r   <= '0;
    end else if (ctl.mul_step) begin
      work_r  <= {work_r[PROD_W-2:0], 1'b0} + addend;
      level_r <= {level_r[LEVEL_W-2:0], 1'b0};
    end else if (ctl.div_step) begin
      // The partial remainder stays below the divisor, so 16 bits hold it.
      rem_r  <= q_bit ? diff[FADE_W-1:0] : trial[FADE_W-1:0];
      work_r <= {work_r[PROD_W-2:0], q_bit};
    end
  end

  assign quot = work_r[LEVEL_W-1:0];

endmodule

FILE: rtl/led_keyframe_fade_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_keyframe_fade_sequencer
// Queues RGB and vibration keyframes and fades the LED levels between them.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one transaction at a time: a load (operation 1)
//   queues a keyframe in the ring, a tick (operation 0) carries the current
//   millisecond time and advances the fade. Every input transaction gives
//   exactly one output transaction with the shown levels, the number of
//   queued keyframes and a flag for a load dropped because the ring is full.
//   States: a load passes ST_LOAD, ST_FIN; a tick on an empty queue passes
//   ST_TICK_RD, ST_FIN; a tick that switches to the next keyframe passes
//   ST_TICK_RD, ST_TICK_EV, ST_FIN. A tick that blends adds ST_CALC (serial
//   multiply, then serial restoring division, six lanes in parallel) and
//   ST_SUM before ST_FIN. in_ready is high only while no transaction is in
//   work, so a new one is taken only after the last has left ST_FIN.
//   A finished result sits in the output register; the next input is taken
//   while it waits, and its own result holds until the receiver takes the
//   pending one.
//   Reset clears the ring, the queue and the shown levels to zero.
// ----------------------------------------------------------------------------
module led_keyframe_fade_sequencer
  import lkf_pkg::*;
#(
  parameter int RING_SLOTS = LKF_RING_SLOTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [TIME_W-1:0]   in_now_ms,
  input  logic [LEVEL_W-1:0]  in_key_red,
  input  logic [LEVEL_W-1:0]  in_key_green,
  input  logic [LEVEL_W-1:0]  in_key_blue,
  input  logic [LEVEL_W-1:0]  in_key_vibro,
  input  logic [FADE_W-1:0]   in_fade_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LEVEL_W-1:0]  out_red,
  output logic [LEVEL_W-1:0]  out_green,
  output logic [LEVEL_W-1:0]  out_blue,
  output logic [LEVEL_W-1:0]  out_vibro,
  output logic [QUEUED_W-1:0] out_queued,
  output logic                out_load_dropped
);

  localparam int SLOT_W  = $clog2(RING_SLOTS);
  localparam int NUM_CH  = 3;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_LOAD    = 7'b0000010,
    ST_TICK_RD = 7'b0000100,
    ST_TICK_EV = 7'b0001000,
    ST_CALC    = 7'b0010000,
    ST_SUM     = 7'b0100000,
    ST_FIN     = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   write_r;
  logic [SLOT_W-1:0]   play_r;
  logic [SLOT_W-1:0]   pend_r;
  logic [TIME_W-1:0]   last_r;
  logic [LEVEL_W-1:0]  shown_r [4];
  logic                drop_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r;

  op_t                 op_r;
  logic [TIME_W-1:0]   now_r;
  kf_t                 key_r;
  logic [FADE_W-1:0]   coef_a_r;
  logic [FADE_W-1:0]   coef_b_r;
  logic [FADE_W-1:0]   period_r;
  logic [LEVEL_W-1:0]  out_lvl_r [4];
  logic [QUEUED_W-1:0] out_queued_r;
  logic                out_drop_r;

  logic [SLOT_W-1:0]   write_next;
  logic [SLOT_W-1:0]   play_next;
  logic [SLOT_W-1:0]   play_prev;
  logic                ring_full;
  logic                in_fire;
  logic                out_free;
  logic [TIME_W-1:0]   elapsed;
  logic                do_switch;
  kf_t                 kf_next;
  kf_t                 kf_cur;
  lane_ctl_t           lane_ctl;
  logic [SLOT_W+QUEUED_W-1:0] pend_ext;

  logic [LEVEL_W-1:0]  from_lvl [NUM_CH];
  logic [LEVEL_W-1:0]  to_lvl   [NUM_CH];
  logic [LEVEL_W-1:0]  part_a   [NUM_CH];
  logic [LEVEL_W-1:0]  part_b   [NUM_CH];

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;

  assign write_next = (write_r == SLOT_W'(RING_SLOTS - 1)) ? '0 : write_r + 1'b1;
  assign play_next  = (play_r == SLOT_W'(RING_SLOTS - 1)) ? '0 : play_r + 1'b1;
  assign play_prev  = (play_r == '0) ? SLOT_W'(RING_SLOTS - 1) : play_r - 1'b1;
  assign ring_full  = (pend_r == SLOT_W'(RING_SLOTS - 1));

  assign elapsed    = now_r - last_r;
  assign do_switch  = ({{(TIME_W-FADE_W){1'b0}}, kf_next.fade} <= elapsed);

  lkf_store #(
    .RING_SLOTS(RING_SLOTS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     ((state_r == ST_LOAD) && !ring_full),
    .wr_addr   (write_r),
    .wr_data   (key_r),
    .rd_addr_a (play_r),
    .rd_addr_b (play_prev),
    .rd_data_a (kf_next),
    .rd_data_b (kf_cur)
  );

  always_comb begin
    lane_ctl.start    = (state_r == ST_TICK_EV) && !do_switch;
    lane_ctl.mul_step = (state_r == ST_CALC) && (step_r < STEP_W'(MUL_STEPS));
    lane_ctl.div_step = (state_r == ST_CALC) && !(step_r < STEP_W'(MUL_STEPS));
  end

  assign from_lvl[0] = kf_cur.red;
  assign from_lvl[1] = kf_cur.green;
  assign from_lvl[2] = kf_cur.blue;
  assign to_lvl[0]   = kf_next.red;
  assign to_lvl[1]   = kf_next.green;
  assign to_lvl[2]   = kf_next.blue;

  // Per channel: from * (period - elapsed) / period and to * elapsed / period.
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    lkf_blend_lane u_lane_from (
      .clk      (clk),
      .ctl      (lane_ctl),
      .level_in (from_lvl[ch]),
      .coef     (coef_a_r),
      .divisor  (period_r),
      .quot     (part_a[ch])
    );
    lkf_blend_lane u_lane_to (
      .clk      (clk),
      .ctl      (lane_ctl),
      .level_in (to_lvl[ch]),
      .coef     (coef_b_r),
      .divisor  (period_r),
      .quot     (part_b[ch])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_operation == OP_LOAD) ? ST_LOAD : ST_TICK_RD;
        end
      end
      ST_LOAD:    state_nxt = ST_FIN;
      ST_TICK_RD: state_nxt = (pend_r == '0) ? ST_FIN : ST_TICK_EV;
      ST_TICK_EV: state_nxt = do_switch ? ST_FIN : ST_CALC;
      ST_CALC: begin
        if (step_r == STEP_W'(CALC_STEPS - 1)) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      write_r     <= '0;
      play_r      <= '0;
      pend_r      <= '0;
      last_r      <= '0;
      shown_r     <= '{default: '0};
      drop_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_LOAD: begin
          drop_r <= ring_full;
          if (!ring_full) begin
            write_r <= write_next;
            pend_r  <= pend_r + 1'b1;
          end
        end
        ST_TICK_RD: begin
          drop_r <= 1'b0;
          step_r <= '0;
        end
        ST_TICK_EV: begin
          if (do_switch) begin
            shown_r[0] <= kf_next.red;
            shown_r[1] <= kf_next.green;
            shown_r[2] <= kf_next.blue;
            shown_r[3] <= kf_next.vibro;
            pend_r     <= pend_r - 1'b1;
            play_r     <= play_next;
            last_r     <= now_r;
          end
        end
        ST_CALC: begin
          step_r <= step_r + 1'b1;
        end
        ST_SUM: begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            shown_r[ch] <= part_a[ch] + part_b[ch];
          end
        end
        default: begin
        end
      endcase

      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign pend_ext = {{QUEUED_W{1'b0}}, pend_r};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= op_t'(in_operation);
      now_r <= in_now_ms;
      key_r <= '{red: in_key_red, green: in_key_green, blue: in_key_blue,
                 vibro: in_key_vibro, fade: in_fade_ms};
    end
    if (state_r == ST_TICK_EV) begin
      // Used only for a blend, where elapsed is below the 16-bit period.
      coef_a_r <= kf_next.fade - elapsed[FADE_W-1:0];
      coef_b_r <= elapsed[FADE_W-1:0];
      period_r <= kf_next.fade;
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_lvl_r    <= shown_r;
      out_queued_r <= pend_ext[QUEUED_W-1:0];
      out_drop_r   <= drop_r && (op_r == OP_LOAD);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_lvl_r[0];
  assign out_green        = out_lvl_r[1];
  assign out_blue         = out_lvl_r[2];
  assign out_vibro        = out_lvl_r[3];
  assign out_queued       = out_queued_r;
  assign out_load_dropped = out_drop_r;

endmodule
